// ===== rtl/grouped_team_queue_defines.svh =====
// Assertion macros for the team queue.
`ifndef GROUPED_TEAM_QUEUE_DEFINES_SVH
`define GROUPED_TEAM_QUEUE_DEFINES_SVH

// Check a consequence in the same cycle.
`define GTQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("team queue check failed");

// Check a consequence in the following cycle.
`define GTQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("team queue check failed");

`endif

// ===== rtl/gtq_pkg.sv =====
// Shared types and constants of the team queue.
`timescale 1ns / 1ps
package gtq_pkg;
    localparam int ELEMENTS = 4096;
    localparam int TEAMS    = 64;
    localparam int CAPACITY = 256;
    localparam int ELEM_W   = 12;
    localparam int TEAM_W   = 6;
    localparam int SLOT_W   = 8;
    localparam int FREE_W   = 9;
    localparam int ORD_W    = 7;

    localparam logic [1:0] FN_LOAD = 2'd0;
    localparam logic [1:0] FN_ENQ  = 2'd1;
    localparam logic [1:0] FN_DEQ  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [ELEM_W-1:0] element_id;
        logic [TEAM_W-1:0] team_id;
    } t_in;

    typedef struct packed {
        logic [ELEM_W-1:0] out_element;
        logic              out_valid;
        logic [1:0]        status;
    } t_out;

    typedef struct packed {
        logic              clr;
        logic [ELEM_W-1:0] clr_idx;
        logic              cap;
        logic              enq_alloc;
        logic              enq_link;
        logic              deq_rd;
        logic              deq_pop;
        logic              deq_fin;
        logic              res_load;
        logic              res_elem;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic waiting;
    } t_sts;
endpackage

// ===== rtl/grouped_team_queue.sv =====
// Top level of the team queue.
`timescale 1ns / 1ps
// Team queue with linked-list storage for 256 elements in 64 teams.
// Request channel i_in_valid/o_in_ready carries func, element_id and team_id:
// load membership, enqueue an element, or dequeue the front element.
// Result channel o_out_valid/i_out_ready carries one result per request:
// the dequeued element with out_valid, and a status (ok, empty, full).
// Load and a dequeue on an empty queue go straight to the result; enqueue,
// if a slot is free, allocates it and, for a team already waiting, links it;
// dequeue reads, pops and finishes. One request is taken at a time, set by
// the read-then-update sequence over the list memories (head, tail, link, free stack).
// After reset the block sweeps the membership table to team 0 and refills
// the free-slot stack; o_in_ready stays low throughout the sweep.
// A result waits in its output register while i_out_ready is low; the next
// request is accepted meanwhile and holds in its last step until the output
// register frees.
module grouped_team_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gtq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gtq_pkg::t_out o_out_data
);
    import gtq_pkg::*;

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic              w_flag;
    logic [1:0]        w_status;
    logic [ELEM_W-1:0] w_elem;

    gtq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_func       (i_in_data.func),
        .o_in_ready   (o_in_ready),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_res_flag   (w_flag),
        .o_res_status (w_status),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    gtq_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_elem  (w_elem)
    );

    assign o_out_data.out_element = w_elem;
    assign o_out_data.out_valid   = w_flag;
    assign o_out_data.status      = w_status;
endmodule

// ===== rtl/gtq_datapath.sv =====
// Datapath of the team queue: memories, list pointers and result element.
`timescale 1ns / 1ps
module gtq_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gtq_pkg::t_in                 i_req,
    input  gtq_pkg::t_cmd                i_cmd,
    output gtq_pkg::t_sts                o_sts,
    output logic [gtq_pkg::ELEM_W-1:0]   o_elem
);
    import gtq_pkg::*;

    logic [TEAM_W-1:0] m_et   [ELEMENTS];
    logic [SLOT_W-1:0] m_fs   [CAPACITY];
    logic [SLOT_W-1:0] m_head [TEAMS];
    logic [SLOT_W-1:0] m_tail [TEAMS];
    logic [SLOT_W-1:0] m_next [CAPACITY];
    logic [ELEM_W-1:0] m_val  [CAPACITY];
    logic [TEAM_W-1:0] m_ord  [TEAMS];

    logic [TEAM_W-1:0] r_et_rd, r_ord_rd, r_t;
    logic [SLOT_W-1:0] r_fs_rd, r_hd_rd, r_tl_rd, r_ln_rd, r_s;
    logic [ELEM_W-1:0] r_lv_rd, r_elem, r_dq, r_oelem;
    logic              r_last;
    logic [FREE_W-1:0] r_free_cnt;
    logic [TEAM_W-1:0] r_ord_head;
    logic [ORD_W-1:0]  r_ord_cnt;
    logic [TEAMS-1:0]  r_waiting;

    logic [FREE_W-1:0] w_free_dec;
    logic [TEAM_W-1:0] w_tl_addr;
    logic [TEAM_W-1:0] w_ord_wr;

    assign w_free_dec = r_free_cnt - FREE_W'(1);
    assign w_tl_addr  = i_cmd.enq_alloc ? r_et_rd : r_ord_rd;
    assign w_ord_wr   = r_ord_head + r_ord_cnt[TEAM_W-1:0];

    assign o_sts.empty   = (r_ord_cnt == '0);
    assign o_sts.full    = (r_free_cnt == '0);
    assign o_sts.waiting = r_waiting[r_et_rd];
    assign o_elem        = r_oelem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            m_et[i_cmd.clr_idx] <= '0;
        end else if (i_cmd.cap && i_req.func == FN_LOAD) begin
            m_et[i_req.element_id] <= i_req.team_id;
        end
        r_et_rd <= m_et[i_req.element_id];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && i_cmd.clr_idx < ELEM_W'(CAPACITY)) begin
            m_fs[i_cmd.clr_idx[SLOT_W-1:0]] <= ~i_cmd.clr_idx[SLOT_W-1:0];
        end else if (i_cmd.deq_pop && r_free_cnt < FREE_W'(CAPACITY)) begin
            m_fs[r_free_cnt[SLOT_W-1:0]] <= r_hd_rd;
        end
        r_fs_rd <= m_fs[w_free_dec[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_ord_rd <= m_ord[r_ord_head];
        end
        if (i_cmd.enq_alloc && !r_waiting[r_et_rd] && r_ord_cnt < ORD_W'(TEAMS)) begin
            m_ord[w_ord_wr] <= r_et_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_alloc && !r_waiting[r_et_rd]) begin
            m_head[r_et_rd] <= r_fs_rd;
        end else if (i_cmd.deq_fin && !r_last) begin
            m_head[r_t] <= r_ln_rd;
        end
        r_hd_rd <= m_head[r_ord_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_alloc && !r_waiting[r_et_rd]) begin
            m_tail[r_et_rd] <= r_fs_rd;
        end else if (i_cmd.enq_link) begin
            m_tail[r_t] <= r_s;
        end
        r_tl_rd <= m_tail[w_tl_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_alloc) begin
            m_next[r_fs_rd] <= '0;
        end else if (i_cmd.enq_link) begin
            m_next[r_tl_rd] <= r_s;
        end
        r_ln_rd <= m_next[r_hd_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_alloc) begin
            m_val[r_fs_rd] <= r_elem;
        end
        r_lv_rd <= m_val[r_hd_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_elem <= i_req.element_id;
        end
        if (i_cmd.enq_alloc) begin
            r_t <= r_et_rd;
            r_s <= r_fs_rd;
        end
        if (i_cmd.deq_rd) begin
            r_t <= r_ord_rd;
        end
        if (i_cmd.deq_pop) begin
            r_last <= (r_hd_rd == r_tl_rd);
        end
        if (i_cmd.deq_fin) begin
            r_dq <= r_lv_rd;
        end
        if (i_cmd.res_load) begin
            r_oelem <= i_cmd.res_elem ? r_dq : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt <= FREE_W'(CAPACITY);
            r_ord_head <= '0;
            r_ord_cnt  <= '0;
            r_waiting  <= '0;
        end else begin
            if (i_cmd.enq_alloc) begin
                r_free_cnt <= w_free_dec;
                if (!r_waiting[r_et_rd]) begin
                    r_waiting[r_et_rd] <= 1'b1;
                    if (r_ord_cnt < ORD_W'(TEAMS)) begin
                        r_ord_cnt <= r_ord_cnt + ORD_W'(1);
                    end
                end
            end
            if (i_cmd.deq_pop) begin
                if (r_free_cnt < FREE_W'(CAPACITY)) begin
                    r_free_cnt <= r_free_cnt + FREE_W'(1);
                end
                if (r_hd_rd == r_tl_rd) begin
                    r_waiting[r_t] <= 1'b0;
                    r_ord_head     <= r_ord_head + TEAM_W'(1);
                    r_ord_cnt      <= r_ord_cnt - ORD_W'(1);
                end
            end
        end
    end
endmodule

// ===== rtl/gtq_ctrl.sv =====
// Controller of the team queue: sequencing, clearing sweep and result handshake.
`timescale 1ns / 1ps
`include "grouped_team_queue_defines.svh"
module gtq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_func,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic           o_res_flag,
    output logic [1:0]     o_res_status,
    input  gtq_pkg::t_sts  i_sts,
    output gtq_pkg::t_cmd  o_cmd
);
    import gtq_pkg::*;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_E1   = 8'b0000_0100,
        S_E2   = 8'b0000_1000,
        S_D1   = 8'b0001_0000,
        S_D2   = 8'b0010_0000,
        S_D3   = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [ELEM_W-1:0] r_clr_cnt;
    logic [1:0]        r_status, n_status;
    logic              r_flag, n_flag;
    logic              r_ovld;
    logic              r_oflag;
    logic [1:0]        r_ostat;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ovld;
    assign o_res_flag   = r_oflag;
    assign o_res_status = r_ostat;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_flag   = r_flag;
        o_cmd    = '0;
        o_cmd.clr_idx  = r_clr_cnt;
        o_cmd.res_elem = r_flag;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (r_clr_cnt == ELEM_W'(ELEMENTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                n_status = ST_OK;
                n_flag   = 1'b0;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    priority if (i_func == FN_ENQ) begin
                        n_state = S_E1;
                    end else if (i_func == FN_DEQ) begin
                        if (i_sts.empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_D1;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_E1: begin
                if (i_sts.full) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.enq_alloc = 1'b1;
                    n_state = i_sts.waiting ? S_E2 : S_DONE;
                end
            end
            S_E2: begin
                o_cmd.enq_link = 1'b1;
                n_state = S_DONE;
            end
            S_D1: begin
                o_cmd.deq_rd = 1'b1;
                n_state = S_D2;
            end
            S_D2: begin
                o_cmd.deq_pop = 1'b1;
                n_state = S_D3;
            end
            S_D3: begin
                o_cmd.deq_fin = 1'b1;
                n_flag  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovld || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_status  <= ST_OK;
            r_flag    <= 1'b0;
            r_ovld    <= 1'b0;
            r_oflag   <= 1'b0;
            r_ostat   <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_flag   <= n_flag;
            if (o_cmd.clr) r_clr_cnt <= r_clr_cnt + ELEM_W'(1);
            if (o_cmd.res_load) begin
                r_ovld  <= 1'b1;
                r_oflag <= r_flag;
                r_ostat <= r_status;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    `GTQ_ASSERT_NEXT(a_stall_hold, r_state == S_DONE && r_ovld && !i_out_ready, r_state == S_DONE)
    `GTQ_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, r_state != S_IDLE)
    `GTQ_ASSERT_NOW(a_flag_ok, o_out_valid && o_res_flag, o_res_status == ST_OK)
endmodule
